### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/pcxrle_pkg.sv
// ---------------------------------------------------------------------------
// pcxrle_pkg
// Types, constants and helpers of the run-length pixel encoder.
// ---------------------------------------------------------------------------
package pcxrle_pkg;

   localparam int unsigned QueueDepth    = 4;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] CountFlag   = 8'd192;
   localparam logic [7:0] ValueCap    = 8'd191;
   localparam logic [5:0] MaxRunReset = 6'd63;

   // up to two closed runs per pixel: one closed by a new value, one by
   // reaching the limit or the end of the frame
   typedef struct packed {
      logic       a_valid;
      logic [7:0] a_value;
      logic [5:0] a_len;
      logic       b_valid;
      logic [7:0] b_value;
      logic [5:0] b_len;
      logic       b_last;
   } run_pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_A_COUNT,
      PH_A_VAL,
      PH_B_COUNT,
      PH_B_VAL
   } phase_type;

   function automatic logic [7:0] cap_value(input logic [7:0] v);
      return (v >= CountFlag) ? ValueCap : v;
   endfunction

   function automatic logic [7:0] count_byte(input logic [5:0] len);
      return CountFlag | {2'b00, len};
   endfunction

endpackage

### rtl/pcxrle_front.sv
// ---------------------------------------------------------------------------
// pcxrle_front
// Accepts pixels, tracks the open run and queues the runs that close.
// ---------------------------------------------------------------------------
module pcxrle_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [5:0]               csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_pixel,
   input  logic                     req_end_of_frame,
   input  pcxrle_pkg::queue_stat_type queue_stat,
   output logic                     push,
   output pcxrle_pkg::run_pair_type push_data
);

   logic [7:0] held_ff, held_in;
   logic [5:0] len_ff, len_in;
   logic [5:0] max_run_ff;
   logic [5:0] limit;
   logic [5:0] base_len;
   logic [5:0] new_len;
   logic       accept;
   logic       close_a;
   logic       close_b;

   always_comb begin
      req_ready = !queue_stat.full;
      accept    = req_valid && !queue_stat.full;
      limit     = (max_run_ff == 6'd0) ? 6'd1 : max_run_ff;
      close_a   = (len_ff != 6'd0) && (req_pixel != held_ff);
      base_len  = close_a ? 6'd0 : len_ff;
      // open run never exceeds 62 here, so no wrap
      new_len   = base_len + 6'd1;
      close_b   = (new_len >= limit) || req_end_of_frame;

      push_data.a_valid = close_a;
      push_data.a_value = pcxrle_pkg::cap_value(held_ff);
      push_data.a_len   = len_ff;
      push_data.b_valid = close_b;
      push_data.b_value = pcxrle_pkg::cap_value(req_pixel);
      push_data.b_len   = new_len;
      push_data.b_last  = req_end_of_frame;
      push              = accept && (close_a || close_b);

      held_in = accept ? req_pixel : held_ff;
      len_in  = accept ? (close_b ? 6'd0 : new_len) : len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= 8'd0;
         len_ff     <= 6'd0;
         max_run_ff <= pcxrle_pkg::MaxRunReset;
      end else begin
         held_ff <= held_in;
         len_ff  <= len_in;
         if (csr_wr_en) begin
            max_run_ff <= csr_wr_data;
         end
      end
   end

endmodule

### rtl/pcxrle_fifo.sv
// ---------------------------------------------------------------------------
// pcxrle_fifo
// Short queue of closed-run pairs between front and back.
// ---------------------------------------------------------------------------
module pcxrle_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pcxrle_pkg::run_pair_type  push_data,
   input  logic                      pop,
   output pcxrle_pkg::run_pair_type  head,
   output pcxrle_pkg::queue_stat_type stat
);

   pcxrle_pkg::run_pair_type entry_ff [pcxrle_pkg::QueueDepth];
   logic [pcxrle_pkg::QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pcxrle_pkg::QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pcxrle_pkg::QueueCntWidth-1:0] cnt_ff, cnt_in;
   logic                                  do_push;
   logic                                  do_pop;

   always_comb begin
      stat.full  = (cnt_ff == pcxrle_pkg::QueueCntWidth'(pcxrle_pkg::QueueDepth));
      stat.empty = (cnt_ff == '0);
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      head       = entry_ff[rd_ptr_ff];
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/pcxrle_back.sv
// ---------------------------------------------------------------------------
// pcxrle_back
// Serializes queued run pairs into count, value and literal bytes.
// ---------------------------------------------------------------------------
module pcxrle_back (
   input  logic                       clock,
   input  logic                       reset,
   input  pcxrle_pkg::run_pair_type   head,
   input  pcxrle_pkg::queue_stat_type stat,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last
);

   pcxrle_pkg::phase_type phase_ff, phase_in;
   pcxrle_pkg::phase_type first_phase;
   pcxrle_pkg::phase_type cur_phase;
   pcxrle_pkg::phase_type nxt_phase;
   pcxrle_pkg::phase_type b_phase;
   logic       load;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   // next state
   always_comb begin
      b_phase = (head.b_len > 6'd1) ? pcxrle_pkg::PH_B_COUNT : pcxrle_pkg::PH_B_VAL;
      if (head.a_valid) begin
         first_phase = (head.a_len > 6'd1) ? pcxrle_pkg::PH_A_COUNT : pcxrle_pkg::PH_A_VAL;
      end else begin
         first_phase = b_phase;
      end
      cur_phase = (phase_ff == pcxrle_pkg::PH_START) ? first_phase : phase_ff;
      load      = !stat.empty && (!valid_ff || rsp_ready);
      unique case (cur_phase)
         pcxrle_pkg::PH_A_COUNT: nxt_phase = pcxrle_pkg::PH_A_VAL;
         pcxrle_pkg::PH_A_VAL:   nxt_phase = head.b_valid ? b_phase : pcxrle_pkg::PH_START;
         pcxrle_pkg::PH_B_COUNT: nxt_phase = pcxrle_pkg::PH_B_VAL;
         pcxrle_pkg::PH_B_VAL:   nxt_phase = pcxrle_pkg::PH_START;
         default:                nxt_phase = pcxrle_pkg::PH_START;
      endcase
      phase_in = load ? nxt_phase : phase_ff;
      pop      = load && (nxt_phase == pcxrle_pkg::PH_START);
   end

   // outputs
   always_comb begin
      unique case (cur_phase)
         pcxrle_pkg::PH_A_COUNT: begin
            byte_in = pcxrle_pkg::count_byte(head.a_len);
            last_in = 1'b0;
         end
         pcxrle_pkg::PH_A_VAL: begin
            byte_in = head.a_value;
            last_in = 1'b0;
         end
         pcxrle_pkg::PH_B_COUNT: begin
            byte_in = pcxrle_pkg::count_byte(head.b_len);
            last_in = 1'b0;
         end
         pcxrle_pkg::PH_B_VAL: begin
            byte_in = head.b_value;
            last_in = head.b_last;
         end
         default: begin
            byte_in = 8'd0;
            last_in = 1'b0;
         end
      endcase
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pcxrle_pkg::PH_START;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

### rtl/pcx_rle_pixel_encoder.sv
// ---------------------------------------------------------------------------
// pcx_rle_pixel_encoder
// PCX-style run-length encoder for 8-bit palette-index pixels.
// ---------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order, req_end_of_frame on the
// last one. Encoded bytes leave on the rsp_ channel, rsp_last on the final
// byte of the frame. A run of one is a literal byte; a longer run is a count
// byte (192 | length) then the value byte; values of 192 and up go out as 191.
// csr_wr_data sets the longest run (0 acts as 1); write it only when idle.
// The front takes one pixel per cycle while its 4-entry run queue has room;
// a request lands in the queue at its accepting edge. The back emits one
// byte per cycle while rsp_ready is high, from the queue head through an
// output register; with an idle back the first byte a request causes is
// loaded into it in the cycle after its accepting edge. A pixel makes up to
// three bytes, but a run never yields more bytes than pixels, so the block
// sustains one pixel per cycle and the queue absorbs the bursts.
// Reset empties the queue and output, drops the open run and sets the
// longest run to 63. When rsp_ready is low the output byte holds, the back
// stops, and req_ready drops once the queue fills.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pcx_rle_pixel_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pixel,
   input  logic       req_end_of_frame,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   pcxrle_pkg::run_pair_type   push_data;
   pcxrle_pkg::run_pair_type   head;
   pcxrle_pkg::queue_stat_type queue_stat;
   logic                       push;
   logic                       pop;

   pcxrle_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .req_end_of_frame (req_end_of_frame),
      .queue_stat       (queue_stat),
      .push             (push),
      .push_data        (push_data)
   );

   pcxrle_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (queue_stat)
   );

   pcxrle_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .stat         (queue_stat),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   // frame ends on a value or literal byte, never on a count byte
   `ASSERT_IMPLY(a_last_not_count, clock, reset, rsp_valid && rsp_last, rsp_out_byte < 8'd192)

   // a count byte always carries a length of two or more
   `ASSERT_IMPLY(a_count_len, clock, reset, rsp_valid && (rsp_out_byte[7:6] == 2'b11),
                 rsp_out_byte[5:0] > 6'd1)

   // the value byte follows its count byte without a gap
   `ASSERT_NEXT(a_value_follows, clock, reset,
                rsp_valid && rsp_ready && (rsp_out_byte[7:6] == 2'b11),
                rsp_valid && (rsp_out_byte[7:6] != 2'b11))

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCX run-length pixel encoder.
// ---------------------------------------------------------------------------
// A queue of pixel requests feeds a valid/ready driver; each accepted request
// runs through a run-length predictor that queues the bytes it should cause.
// A monitor pops one expectation per accepted byte and compares byte and
// last flag. Directed frames cover literals, counted runs, the 191 cap,
// run-limit closes and a lowered limit; random phases follow, each under
// its own limit and its own mix of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [7:0] pixel;
      logic       eof;
   } pixel_req_type;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } encoded_byte_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_pixel = '0;
   logic       req_end_of_frame = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   pixel_req_type    pix_pending[$];
   encoded_byte_type byte_expect[$];

   // predictor state
   logic [7:0] run_px;
   logic [5:0] run_len;
   logic [5:0] run_max;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;

   pcx_rle_pixel_encoder uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---- run-length predictor ----
   task automatic close_run(input logic final_run);
      logic [7:0] v;
      v = (run_px >= pcxrle_pkg::CountFlag) ? pcxrle_pkg::ValueCap : run_px;
      if (run_len <= 6'd1) begin
         byte_expect.push_back('{value: v, last: final_run});
      end else begin
         byte_expect.push_back('{value: pcxrle_pkg::CountFlag | {2'b00, run_len},
                                 last: 1'b0});
         byte_expect.push_back('{value: v, last: final_run});
      end
      run_len = '0;
   endtask

   task automatic encode_pixel(input logic [7:0] px, input logic eof);
      logic [5:0] limit;
      limit = (run_max == 6'd0) ? 6'd1 : run_max;
      // a differing pixel closes the open run before it starts its own
      if (run_len != 6'd0 && px != run_px)
         close_run(1'b0);
      if (run_len == 6'd0) begin
         run_px = px;
         run_len = 6'd1;
      end else begin
         run_len = run_len + 6'd1;
      end
      if (run_len >= limit || eof)
         close_run(eof);
   endtask

   // ---- request driver ----
   always @(posedge clock) begin : req_driver
      pixel_req_type nxt;
      logic          launch;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            encode_pixel(req_pixel, req_end_of_frame);
         if (!req_valid || req_ready) begin
            launch = (pix_pending.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (launch) begin
               nxt = pix_pending.pop_front();
               req_pixel <= nxt.pixel;
               req_end_of_frame <= nxt.eof;
            end
            req_valid <= launch;
         end
      end
   end

   // ---- byte monitor ----
   always @(posedge clock) begin : rsp_monitor
      encoded_byte_type exp_b;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (byte_expect.size() == 0) begin
               $display("%0t: unexpected byte: expected none, actual byte %h last %b",
                        $time, rsp_out_byte, rsp_last);
               error_count++;
            end else begin
               exp_b = byte_expect.pop_front();
               if (rsp_out_byte !== exp_b.value) begin
                  $display("%0t: byte mismatch: expected %h, actual %h",
                           $time, exp_b.value, rsp_out_byte);
                  error_count++;
               end
               if (rsp_last !== exp_b.last) begin
                  $display("%0t: last mismatch: expected %b, actual %b",
                           $time, exp_b.last, rsp_last);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---- stimulus helpers ----
   task automatic queue_run(input logic [7:0] v, input int len, input logic eof_at_end);
      for (int i = 0; i < len; i++)
         pix_pending.push_back('{pixel: v, eof: eof_at_end && (i == len - 1)});
   endtask

   // block can hold an open run with nothing to send, so let the clock run on once the queues drain
   task automatic wait_idle();
      while (pix_pending.size() != 0 || req_valid || byte_expect.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_max_run(input logic [5:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      run_max = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_random_stream(input int n_items);
      int         left;
      int         len;
      int         pick;
      logic [7:0] v;
      left = n_items;
      while (left > 0) begin
         pick = $urandom_range(99);
         // bias some values around the count flag boundary
         if (pick < 15)
            v = 8'($urandom_range(195, 188));
         else
            v = 8'($urandom_range(255));
         len = (pick % 4 == 0) ? $urandom_range(12, 1) : $urandom_range(3, 1);
         if (len > left)
            len = left;
         queue_run(v, len, $urandom_range(99) < 12);
         left -= len;
      end
   endtask

   // ---- test sequence ----
   initial begin
      run_px = '0;
      run_len = '0;
      run_max = pcxrle_pkg::MaxRunReset;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // default limit: literal, counted run with capped value, cap boundary
      queue_run(8'd0, 1, 1'b0);
      queue_run(8'd255, 2, 1'b0);
      queue_run(8'd192, 1, 1'b0);
      queue_run(8'd191, 1, 1'b0);
      queue_run(8'd7, 3, 1'b0);
      queue_run(8'd128, 1, 1'b1);
      wait_idle();

      // zero limit acts as one: every pixel literal
      write_max_run(6'd0);
      queue_run(8'd9, 2, 1'b0);
      queue_run(8'd200, 1, 1'b1);
      wait_idle();

      // run closes on reaching the limit; differing pixel flushes first
      write_max_run(6'd3);
      queue_run(8'd5, 4, 1'b0);
      queue_run(8'd6, 1, 1'b1);
      wait_idle();

      // limit lowered under an open run
      write_max_run(6'd63);
      queue_run(8'd40, 5, 1'b0);
      wait_idle();
      write_max_run(6'd2);
      queue_run(8'd40, 1, 1'b0);
      queue_run(8'd41, 1, 1'b1);
      wait_idle();

      // random phases
      write_max_run(6'd63);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queue_run(8'd255, 65, 1'b0);
      queue_random_stream(10);
      wait_idle();

      write_max_run(6'd1);
      send_idle_pct = 47;
      rsp_stall_pct = 0;
      queue_random_stream(62);
      wait_idle();

      write_max_run(6'($urandom_range(8, 2)));
      send_idle_pct = 0;
      rsp_stall_pct = 47;
      queue_random_stream(62);
      wait_idle();

      write_max_run(6'd63);
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      queue_random_stream(62);
      wait_idle();

      write_max_run(6'($urandom_range(63, 1)));
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queue_random_stream(31);
      wait_idle();
      // sender idle mid-phase until all bytes are back
      queue_random_stream(31);
      queue_run(8'd17, 1, 1'b1);
      wait_idle();

      repeat (20) @(negedge clock);
      if (error_count == 0 && byte_expect.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
